// ===== rtl/integer_set_table_top_defines.svh =====
// Assertion macros shared by the integer set table RTL.
`ifndef INTEGER_SET_TABLE_TOP_DEFINES_SVH
`define INTEGER_SET_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ist_pkg.sv =====
// Types, codes and constants shared by the integer set table modules.
`timescale 1ns / 1ps

package ist_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int KIND_W       = 2;
    localparam int COUNT_OUT_W  = 7;
    localparam int QUEUE_DEPTH  = 2;
    localparam int OUT_TDATA_W  = 16;

    // Command codes as they arrive on the stream.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_QUERY,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic                   ok;
        logic                   full_reject;
        logic [COUNT_OUT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic busy;
        logic full;
    } t_back_status;

endpackage

// ===== rtl/integer_set_table_top.sv =====
// Top level of the integer set table: front end, command queue and back end.
`timescale 1ns / 1ps
`include "integer_set_table_top_defines.svh"

// Holds up to CAPACITY distinct 32-bit values in an unordered RAM with a count.
// Each item on the input stream is an insert, remove or membership query and
// yields exactly one result item with a success flag, a full flag and the new
// count. The back end compares one stored entry per cycle through the single
// read port of the element RAM, a hit ends the scan early, and a remove that
// hits adds a move step that fills the hole with the last entry. A two-entry
// command queue lets the input side keep taking items while the back end works
// or a result waits. The RAM needs no clearing after reset, since only entries
// below the count are ever used.
module integer_set_table_top
    import ist_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [VALUE_W-1:0]     s_axis_tdata,  // value
    input  logic [KIND_W-1:0]      s_axis_tuser,  // kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // ok, full_reject, count[6:0], zero pad
);

    localparam int                     CW    = $clog2(CAPACITY + 1);
    localparam logic [CW+COUNT_OUT_W-1:0] CAP_EXT = (CW + COUNT_OUT_W)'(CAPACITY);

    t_cmd         w_cmd;
    logic         w_cmd_valid;
    logic         w_cmd_ready;
    t_back_status w_status;

    ist_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd         (w_cmd),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready)
    );

    ist_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_ready   (w_cmd_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_status      (w_status)
    );

    `IST_ASSERT_NEXT(a_pop_starts_work, w_cmd_valid && w_cmd_ready, w_status.busy, "back end idle after taking a command")
    `IST_ASSERT_SAME(a_result_after_work, $rose(m_axis_tvalid), $past(w_status.busy), "result item without back end work")
    `IST_ASSERT_SAME(a_reject_only_full, $rose(m_axis_tvalid) && m_axis_tdata[1], $past(w_status.full), "full reject while store not full")
    `IST_ASSERT_SAME(a_reject_count, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[8:2] == CAP_EXT[COUNT_OUT_W-1:0], "full reject with wrong count")

endmodule

// ===== rtl/ist_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ist_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ist_front.sv =====
// Front end: takes items off the input stream, decodes the command and queues it.
`timescale 1ns / 1ps

module ist_front
    import ist_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,  // value
    input  logic [KIND_W-1:0]  s_axis_tuser,  // kind
    output t_cmd               o_cmd,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready
);

    localparam int QP_W = $clog2(QUEUE_DEPTH);
    localparam int QF_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wptr, n_wptr;
    logic [QP_W-1:0]  r_rptr, n_rptr;
    logic [QF_W-1:0]  r_fill, n_fill;
    t_op              w_op;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        unique case (s_axis_tuser)
            KIND_INSERT: w_op = OP_INSERT;
            KIND_REMOVE: w_op = OP_REMOVE;
            KIND_QUERY:  w_op = OP_QUERY;
            default:     w_op = OP_NOP;
        endcase
    end

    assign s_axis_tready = (r_fill != QF_W'(QUEUE_DEPTH));
    assign o_cmd_valid   = (r_fill != '0);
    assign o_cmd         = r_q[r_rptr];
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign w_pop         = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (w_push) begin
            n_wptr = (r_wptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= '{op: w_op, value: s_axis_tdata};
        end
    end

endmodule

// ===== rtl/ist_back.sv =====
// Back end: scans the element RAM, updates the set and registers the result item.
`timescale 1ns / 1ps

module ist_back
    import ist_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_ready,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // ok, full_reject, count[6:0], zero pad
    output t_back_status           o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SCAN    = 4'b0010,
        S_RESOLVE = 4'b0100,
        S_MOVE    = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    t_cmd                      r_cmd, n_cmd;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx, n_idx;
    logic                      r_pend, n_pend;
    logic [AW-1:0]             r_pend_idx, n_pend_idx;
    logic                      r_found, n_found;
    logic [AW-1:0]             r_pos, n_pos;
    logic                      r_out_valid, n_out_valid;
    t_result                   r_out, n_out;

    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [VALUE_W-1:0]        w_wdata;
    logic [AW-1:0]             w_raddr;
    logic [VALUE_W-1:0]        w_rdata;
    logic [AW-1:0]             w_last_idx;
    logic                      w_hit;
    logic                      w_last;
    logic                      w_ok;
    logic                      w_full;
    logic                      w_emit;
    logic [CW+COUNT_OUT_W-1:0] w_cnt_ext;

    ist_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_last_idx = AW'(r_count - 1'b1);
    assign w_hit      = r_pend && (w_rdata == r_cmd.value);
    assign w_last     = r_pend && (r_pend_idx == w_last_idx);
    // The move of a remove needs the last entry, fetched while resolving.
    assign w_raddr    = (r_state == S_RESOLVE) ? w_last_idx : r_idx[AW-1:0];
    assign o_cmd_ready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_cnt_ext   = {{COUNT_OUT_W{1'b0}}, n_count};

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_found     = r_found;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_cmd.value;
        w_ok        = 1'b0;
        w_full      = 1'b0;
        w_emit      = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_state = (i_cmd.op == OP_NOP || r_count == '0) ? S_RESOLVE : S_SCAN;
                end
            end
            S_SCAN: begin
                // One read is issued per cycle; its data is compared in the next cycle.
                if (w_hit) begin
                    n_found = 1'b1;
                    n_pos   = r_pend_idx;
                    n_state = S_RESOLVE;
                end else if (w_last) begin
                    n_state = S_RESOLVE;
                end else begin
                    n_pend     = (r_idx < r_count);
                    n_pend_idx = r_idx[AW-1:0];
                    n_idx      = r_idx + 1'b1;
                end
            end
            S_RESOLVE: begin
                n_state = S_IDLE;
                w_emit  = 1'b1;
                case (r_cmd.op)
                    OP_INSERT: begin
                        if (r_found) begin
                            w_ok = 1'b1;
                        end else if (r_count == CW'(CAPACITY)) begin
                            w_full = 1'b1;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_count[AW-1:0];
                            n_count = r_count + 1'b1;
                            w_ok    = 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_found) begin
                            w_emit  = 1'b0;
                            n_state = S_MOVE;
                        end
                    end
                    OP_QUERY: w_ok = r_found;
                    default:  w_ok = 1'b0;
                endcase
            end
            S_MOVE: begin
                // The last entry fills the hole left by the removed one.
                w_we    = 1'b1;
                w_waddr = r_pos;
                w_wdata = w_rdata;
                n_count = r_count - 1'b1;
                w_ok    = 1'b1;
                w_emit  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out       = '{ok: w_ok, full_reject: w_full,
                            count: w_cnt_ext[COUNT_OUT_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_out      <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.count, r_out.full_reject, r_out.ok});
    assign o_status      = '{busy: (r_state != S_IDLE), full: (r_count == CW'(CAPACITY))};

endmodule
